### sv/fapm_pkg.sv
// shared constants and types for the pattern search block
package fapm_pkg;

    localparam int MAX_PATTERN = 32;
    localparam int IDX_W       = $clog2(MAX_PATTERN);
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
    localparam int SYM_W       = 8;
    localparam int POS_W       = 16;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_SCAN = 1'b1;

    typedef struct packed {
        logic             scan;
        logic             clear;
        logic [SYM_W-1:0] symbol;
    } t_cell_ctl;

endpackage

### sv/fapm_in_if.sv
// input channel: command, pattern index, symbol and text start flag
interface fapm_in_if;
    import fapm_pkg::*;

    logic             valid;
    logic             ready;
    logic             command;
    logic [IDX_W-1:0] pattern_index;
    logic [SYM_W-1:0] symbol;
    logic             first_of_text;

    modport source (output valid, command, pattern_index, symbol, first_of_text,
                    input ready);
    modport sink   (input valid, command, pattern_index, symbol, first_of_text,
                    output ready);
endinterface

### sv/fapm_out_if.sv
// result channel: match flag, match start and automaton state
interface fapm_out_if;
    import fapm_pkg::*;

    logic             valid;
    logic             ready;
    logic             match_found;
    logic [POS_W-1:0] match_start;
    logic [LEN_W-1:0] automaton_state;

    modport source (output valid, match_found, match_start, automaton_state,
                    input ready);
    modport sink   (input valid, match_found, match_start, automaton_state,
                    output ready);
endinterface

### sv/fapm_cell.sv
// one pattern position: stored byte and its prefix-match bit
module fapm_cell (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  fapm_pkg::t_cell_ctl         i_ctl,
    input  logic                        i_wr,
    input  logic                        i_active,
    input  logic                        i_prev,
    output logic                        o_bit,
    output logic                        o_next
);
    import fapm_pkg::*;

    logic [SYM_W-1:0] r_byte;
    logic             r_bit;
    logic             n_bit;

    // prefix ending here extends the prefix one shorter held by the left neighbor
    always_comb begin
        n_bit = i_active && i_prev && (r_byte == i_ctl.symbol);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= 1'b0;
        end else if (i_ctl.clear) begin
            r_bit <= 1'b0;
        end else if (i_ctl.scan) begin
            r_bit <= n_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_byte <= i_ctl.symbol;
        end
    end

    assign o_bit  = r_bit;
    assign o_next = n_bit;
endmodule

### sv/finite_automaton_pattern_search.sv
// Single-pattern byte stream search built from a row of match cells.
// Input channel i_in carries one beat per item: command selects a pattern
// load (writes symbol at pattern_index, clears the match state, no result)
// or a text scan (one result beat on o_out). first_of_text on a scan
// restarts the match state and the text position before that byte.
// i_cfg_we/i_cfg_wdata set the pattern length; write it only while idle.
// Each scan updates every cell at once, so one beat is accepted per cycle
// while i_in.ready is high. A scan is captured by the cell row and a
// snapshot register together, then goes through a priority encoder into the
// output register. o_out reports the longest matched prefix, a match flag and the
// match start position modulo 65536.
// Reset clears the match bits, the text position and the output stage and
// sets the pattern length to 1; pattern bytes must be loaded before use.
// When the receiver holds ready low the result and snapshot registers fill
// and i_in.ready drops; nothing is lost and the cells hold their state.
module finite_automaton_pattern_search (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    fapm_in_if.sink                      i_in,
    fapm_out_if.source                   o_out,
    input  logic                         i_cfg_we,
    input  logic [fapm_pkg::LEN_W-1:0]   i_cfg_wdata
);
    import fapm_pkg::*;

    logic [LEN_W-1:0]       r_len;
    logic [LEN_W-1:0]       eff_len;
    logic [POS_W-1:0]       r_pos;
    logic [POS_W-1:0]       here;

    logic                   accept;
    logic                   s1_adv;
    logic                   s2_adv;
    t_cell_ctl              ctl;

    logic [MAX_PATTERN-1:0] bits;
    logic [MAX_PATTERN-1:0] next_bits;
    logic [MAX_PATTERN-1:0] prev;

    logic                   r_s1_valid;
    logic [MAX_PATTERN-1:0] r_s1_vec;
    logic [POS_W-1:0]       r_s1_pos;
    logic [LEN_W-1:0]       r_s1_len;

    logic [LEN_W-1:0]       best;
    logic [LEN_W-1:0]       last_k;
    logic                   found;

    logic                   r_out_valid;
    logic                   r_out_found;
    logic [POS_W-1:0]       r_out_start;
    logic [LEN_W-1:0]       r_out_state;

    always_comb begin
        if (r_len == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_len > LEN_W'(MAX_PATTERN)) begin
            eff_len = LEN_W'(MAX_PATTERN);
        end else begin
            eff_len = r_len;
        end
    end

    assign s2_adv     = !r_out_valid || o_out.ready;
    assign s1_adv     = !r_s1_valid || s2_adv;
    assign i_in.ready = s1_adv;
    assign accept     = i_in.valid && s1_adv;

    assign ctl.scan   = accept && (i_in.command == CMD_SCAN);
    assign ctl.clear  = accept && (i_in.command == CMD_LOAD);
    assign ctl.symbol = i_in.symbol;

    assign here = i_in.first_of_text ? '0 : r_pos;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        if (k == 0) begin : g_head
            assign prev[k] = 1'b1;
        end else begin : g_body
            assign prev[k] = bits[k-1] && !i_in.first_of_text;
        end

        fapm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctl    (ctl),
            .i_wr     (ctl.clear && (i_in.pattern_index == IDX_W'(k))),
            .i_active (LEN_W'(k) < eff_len),
            .i_prev   (prev[k]),
            .o_bit    (bits[k]),
            .o_next   (next_bits[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len <= LEN_W'(1);
            r_pos <= '0;
        end else begin
            if (i_cfg_we) begin
                r_len <= i_cfg_wdata;
            end
            if (ctl.scan) begin
                r_pos <= here + POS_W'(1);
            end
        end
    end

    // snapshot of the updated match vector for the encoder stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= ctl.scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && ctl.scan) begin
            r_s1_vec <= next_bits;
            r_s1_pos <= here;
            r_s1_len <= eff_len;
        end
    end

    // bits at or above the length are already zero, so the top set bit wins
    always_comb begin
        best = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (r_s1_vec[k]) begin
                best = LEN_W'(k + 1);
            end
        end
        last_k = r_s1_len - LEN_W'(1);
        found  = r_s1_vec[last_k[IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv && r_s1_valid) begin
            r_out_found <= found;
            r_out_start <= found ? (r_s1_pos + POS_W'(1) - POS_W'(r_s1_len)) : '0;
            r_out_state <= best;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.match_found     = r_out_found;
    assign o_out.match_start     = r_out_start;
    assign o_out.automaton_state = r_out_state;
endmodule

### verif/tb_top.sv
// testbench for the pattern search block: scoreboard with its own automaton predictor, random traffic
import fapm_pkg::*;

typedef struct packed {
    logic             match_found;
    logic [POS_W-1:0] match_start;
    logic [LEN_W-1:0] automaton_state;
} scan_result_t;

class match_scoreboard;
    logic [SYM_W-1:0]       pattern_bytes [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] prefix_hits;
    logic [POS_W-1:0]       next_position;
    logic [LEN_W-1:0]       length_reg;
    scan_result_t           expected_scans [$];
    int                     mismatches;

    function new();
        prefix_hits   = '0;
        next_position = '0;
        length_reg    = LEN_W'(1);
        mismatches    = 0;
        foreach (pattern_bytes[k]) pattern_bytes[k] = '0;
    endfunction

    function void set_length(logic [LEN_W-1:0] value);
        length_reg = value;
    endfunction

    function int pending();
        return expected_scans.size();
    endfunction

    function void flag_error(string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endfunction

    // works out the result beat of one accepted input beat
    function void note_input(logic command, logic [IDX_W-1:0] index,
                             logic [SYM_W-1:0] symbol, logic first);
        int           len;
        int           best;
        int           k;
        scan_result_t res;
        if (command == CMD_LOAD) begin
            pattern_bytes[index] = symbol;
            prefix_hits = '0;
            return;
        end
        if (first) begin
            prefix_hits   = '0;
            next_position = '0;
        end
        if (length_reg == 0)
            len = 1;
        else if (length_reg > MAX_PATTERN)
            len = MAX_PATTERN;
        else
            len = int'(length_reg);
        for (k = MAX_PATTERN - 1; k >= len; k--) prefix_hits[k] = 1'b0;
        // top down so each prefix extends the old shorter one
        for (k = len - 1; k > 0; k--)
            prefix_hits[k] = prefix_hits[k-1] && (pattern_bytes[k] == symbol);
        prefix_hits[0] = (pattern_bytes[0] == symbol);
        best = 0;
        for (k = 0; k < len; k++) if (prefix_hits[k]) best = k + 1;
        res.automaton_state = LEN_W'(best);
        if (best == len) begin
            res.match_found = 1'b1;
            res.match_start = POS_W'(int'(next_position) + 1 - len);
        end else begin
            res.match_found = 1'b0;
            res.match_start = '0;
        end
        next_position = next_position + 1'b1;
        expected_scans.push_back(res);
    endfunction

    function void check_result(scan_result_t got);
        scan_result_t exp;
        if (expected_scans.size() == 0) begin
            flag_error($sformatf("unexpected result beat: found=%0d start=%0d state=%0d",
                                 got.match_found, got.match_start, got.automaton_state));
            return;
        end
        exp = expected_scans.pop_front();
        if (got.match_found !== exp.match_found || got.match_start !== exp.match_start ||
            got.automaton_state !== exp.automaton_state)
            flag_error($sformatf({"mismatch: expected found=%0d start=%0d state=%0d,",
                                  " got found=%0d start=%0d state=%0d"},
                                 exp.match_found, exp.match_start, exp.automaton_state,
                                 got.match_found, got.match_start, got.automaton_state));
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200_000;

    typedef enum {RX_OPEN, RX_COIN, RX_MOSTLY, RX_STALL} rx_mode_e;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             cfg_we;
    logic [LEN_W-1:0] cfg_wdata;

    fapm_in_if  in_bus ();
    fapm_out_if out_bus ();

    finite_automaton_pattern_search dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_bus),
        .o_out       (out_bus),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata)
    );

    match_scoreboard  board;
    int               cycle_count = 0;
    int               burst_left = 0;
    bit               long_hold_req = 1'b0;
    bit               restart_next;
    logic [SYM_W-1:0] pat_copy [MAX_PATTERN];
    logic [SYM_W-1:0] alphabet [3];
    int               alpha_n = 2;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        scan_result_t got;
        if (i_rst_n && out_bus.valid === 1'b1 && out_bus.ready) begin
            got.match_found     = out_bus.match_found;
            got.match_start     = out_bus.match_start;
            got.automaton_state = out_bus.automaton_state;
            board.check_result(got);
        end
    end

    // receiver: segments of open, coin-flip, mostly-open and stalled ready, plus a long hold on request
    initial begin
        rx_mode_e mode;
        int       span;
        out_bus.ready = 1'b0;
        @(negedge i_clk);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                out_bus.ready <= 1'b0;
                repeat (80) @(negedge i_clk);
            end else begin
                mode = rx_mode_e'($urandom_range(0, 3));
                span = (mode == RX_STALL) ? $urandom_range(1, 6) : $urandom_range(1, 30);
                repeat (span) begin
                    case (mode)
                        RX_OPEN:   out_bus.ready <= 1'b1;
                        RX_COIN:   out_bus.ready <= 1'($urandom_range(0, 1));
                        RX_MOSTLY: out_bus.ready <= ($urandom_range(0, 3) != 0);
                        default:   out_bus.ready <= 1'b0;
                    endcase
                    @(negedge i_clk);
                end
            end
        end
    end

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_item(logic command, logic [IDX_W-1:0] index,
                             logic [SYM_W-1:0] symbol, logic first);
        int gap;
        if (burst_left == 0) begin
            if ($urandom_range(0, 99) < 30)
                gap = 0;
            else if ($urandom_range(0, 19) == 0)
                gap = $urandom_range(10, 20);
            else
                gap = $urandom_range(1, 5);
            burst_left = $urandom_range(1, 24);
            repeat (gap) begin
                in_bus.valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        burst_left--;
        in_bus.valid         <= 1'b1;
        in_bus.command       <= command;
        in_bus.pattern_index <= index;
        in_bus.symbol        <= symbol;
        in_bus.first_of_text <= first;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        board.note_input(command, index, symbol, first);
        @(negedge i_clk);
    endtask

    task automatic scan_byte(logic [SYM_W-1:0] symbol, logic first);
        send_item(CMD_SCAN, IDX_W'($urandom), symbol, first);
    endtask

    task automatic scan_next(logic [SYM_W-1:0] symbol);
        scan_byte(symbol, restart_next);
        restart_next = 1'b0;
    endtask

    task automatic load_byte(int index, logic [SYM_W-1:0] symbol);
        pat_copy[index] = symbol;
        send_item(CMD_LOAD, IDX_W'(index), symbol, 1'($urandom_range(0, 1)));
    endtask

    // loads make no result beat, so let the pipe drain past the last result
    task automatic settle();
        in_bus.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic write_length(int value);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= LEN_W'(value);
        @(negedge i_clk);
        cfg_we <= 1'b0;
        board.set_length(LEN_W'(value));
    endtask

    task automatic pick_alphabet();
        alpha_n = $urandom_range(2, 3);
        foreach (alphabet[k]) alphabet[k] = SYM_W'($urandom);
    endtask

    function automatic logic [SYM_W-1:0] alpha_sym();
        return alphabet[$urandom_range(0, alpha_n - 1)];
    endfunction

    task automatic run_phase(int length_value, int budget);
        int len;
        int scans;
        int part;
        int cut;
        int k;
        write_length(length_value);
        len = (length_value == 0) ? 1 : (length_value > MAX_PATTERN) ? MAX_PATTERN : length_value;
        pick_alphabet();
        for (k = 0; k < len; k++) load_byte(k, alpha_sym());
        if (len == MAX_PATTERN) long_hold_req = 1'b1;
        restart_next = 1'b1;
        scans = 0;
        while (scans < budget) begin
            part = $urandom_range(0, 99);
            if (part < 55) begin
                for (k = 0; k < len; k++) scan_next(pat_copy[k]);
                scans += len;
            end else if (part < 75) begin
                // broken copy: a prefix then a stray byte
                cut = (len > 1) ? $urandom_range(1, len - 1) : 1;
                for (k = 0; k < cut; k++) scan_next(pat_copy[k]);
                scan_next(alpha_sym());
                scans += cut + 1;
            end else if (part < 88) begin
                repeat ($urandom_range(1, 4)) begin
                    scan_next($urandom_range(0, 1) ? SYM_W'($urandom) : alpha_sym());
                    scans++;
                end
            end else if (part < 94) begin
                load_byte($urandom_range(0, MAX_PATTERN - 1), alpha_sym());
            end else begin
                restart_next = 1'b1;
            end
        end
    endtask

    initial begin
        int lengths [12];
        int k;
        lengths = '{0, 32, 63, 33, 1, 2, 3, 5, 7, 12, 20, 31};
        board = new();
        i_rst_n              = 1'b0;
        cfg_we               = 1'b0;
        cfg_wdata            = '0;
        in_bus.valid         = 1'b0;
        in_bus.command       = CMD_LOAD;
        in_bus.pattern_index = '0;
        in_bus.symbol        = '0;
        in_bus.first_of_text = 1'b0;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset length of one, then a four byte pattern with overlap and clearing
        load_byte(0, 8'hFF);
        scan_byte(8'hFF, 1'b1);
        scan_byte(8'h00, 1'b0);
        write_length(4);
        load_byte(0, 8'h00);
        load_byte(1, 8'hFF);
        load_byte(2, 8'h00);
        load_byte(3, 8'hFF);
        load_byte(MAX_PATTERN - 1, 8'h00);
        scan_byte(8'h00, 1'b1);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b0);
        load_byte(2, 8'h00);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b0);
        scan_byte(8'hFF, 1'b0);
        scan_byte(8'h00, 1'b1);
        scan_byte(8'h7F, 1'b0);

        // every store entry is written from here on
        for (k = 0; k < MAX_PATTERN; k++) load_byte(k, SYM_W'($urandom));

        foreach (lengths[p]) run_phase(lengths[p], (lengths[p] >= 16) ? 90 : 40);
        run_phase($urandom_range(1, MAX_PATTERN), 60);

        settle();
        repeat (4) @(negedge i_clk);
        if (board.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

### sim.f
sv/fapm_pkg.sv
sv/fapm_in_if.sv
sv/fapm_out_if.sv
sv/fapm_cell.sv
sv/finite_automaton_pattern_search.sv
verif/tb_top.sv
